// File: rtl/lsbs_pkg.sv
// Package for the LCG substitution-box byte scrambler.
// Holds the opcodes, register indexes, generator constants and controller types.
// No dependencies.
package lsbs_pkg;

    localparam int unsigned SWAP_W = 13;

    localparam logic [31:0] LCG_MUL          = 32'h0808_8405;
    localparam logic [31:0] KEY_SEED_RESET   = 32'h0131_A9D3;
    localparam logic [31:0] TABLE_SEED_RESET = 32'h0132_9436;
    localparam logic [4:0]  MULT_RESET       = 5'd8;

    localparam logic [1:0] OP_BUILD = 2'd0;
    localparam logic [1:0] OP_ENC   = 2'd1;
    localparam logic [1:0] OP_DEC   = 2'd2;

    localparam logic [1:0] CFG_KEY_SEED   = 2'd0;
    localparam logic [1:0] CFG_TABLE_SEED = 2'd1;
    localparam logic [1:0] CFG_MULT       = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAIN,
        S_FILL,
        S_DRAW_A,
        S_DRAW_B,
        S_WR_A,
        S_WR_B,
        S_INV_RD,
        S_INV_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic build_init;
        logic fill_wr;
        logic draw_a;
        logic draw_b;
        logic swap_wr_a;
        logic swap_wr_b;
        logic inv_rd;
        logic inv_wr;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic is_build;
        logic p_valid;
        logic p_free;
        logic idx_last;
        logic b_differs;
        logic swaps_zero;
        logic swaps_last;
    } t_stat;

    function automatic logic [31:0] lcg_next(input logic [31:0] x);
        logic [31:0] prod;
        prod = x * LCG_MUL;
        return prod + 32'd1;
    endfunction

endpackage

// File: rtl/lcg_sbox_byte_scrambler.sv
// Byte ops: one transfer per cycle unless stalled or building; lookup stage, then output register.
// Build: no input taken; multiplier * 256 swaps go through the single write port
// of the forward table (two writes per swap).
// Reset (synchronous, active low) restores the seed registers and clears the
// keystream generator and handshake state; both tables stay undefined until a build.
module lcg_sbox_byte_scrambler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_in
    input  logic [2:0]  i_s_axis_tuser,   // [1:0] opcode, [2] first_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] data_out
    output logic        o_m_axis_tuser    // [0] is_data
);

    lsbs_pkg::t_cmd  cmd;
    lsbs_pkg::t_stat stat;

    lsbs_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    lsbs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

    a_build_p_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.fill_wr || cmd.draw_a || cmd.draw_b || cmd.inv_rd || cmd.done) |-> !stat.p_valid)
        else $error("lookup stage busy during table build");

    a_build_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.take && stat.is_build) |=> !o_s_axis_tready)
        else $error("input taken right after build start");

    a_swap_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.swap_wr_a |=> cmd.swap_wr_b)
        else $error("swap write pair broken");

    a_done_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.done |=> stat.p_valid)
        else $error("build completion not queued");

endmodule

// File: rtl/lsbs_ctrl.sv
// Controller for the byte scrambler: input handshake and table build sequencing.
// Depends on lsbs_pkg; drives lsbs_dp through t_cmd and reads t_stat.
module lsbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  lsbs_pkg::t_stat i_stat,
    output lsbs_pkg::t_cmd  o_cmd
);

    lsbs_pkg::t_state r_state;
    lsbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            lsbs_pkg::S_IDLE: begin
                o_s_axis_tready = i_stat.p_free;
                o_cmd.take      = i_s_axis_tvalid && i_stat.p_free;
                if (o_cmd.take && i_stat.is_build) begin
                    n_state = lsbs_pkg::S_DRAIN;
                end
            end
            lsbs_pkg::S_DRAIN: begin
                if (!i_stat.p_valid) begin
                    o_cmd.build_init = 1'b1;
                    n_state          = lsbs_pkg::S_FILL;
                end
            end
            lsbs_pkg::S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = i_stat.swaps_zero ? lsbs_pkg::S_INV_RD : lsbs_pkg::S_DRAW_A;
                end
            end
            lsbs_pkg::S_DRAW_A: begin
                o_cmd.draw_a = 1'b1;
                n_state      = lsbs_pkg::S_DRAW_B;
            end
            lsbs_pkg::S_DRAW_B: begin
                o_cmd.draw_b = 1'b1;
                if (i_stat.b_differs) begin
                    n_state = lsbs_pkg::S_WR_A;
                end
            end
            lsbs_pkg::S_WR_A: begin
                o_cmd.swap_wr_a = 1'b1;
                n_state         = lsbs_pkg::S_WR_B;
            end
            lsbs_pkg::S_WR_B: begin
                o_cmd.swap_wr_b = 1'b1;
                n_state = i_stat.swaps_last ? lsbs_pkg::S_INV_RD : lsbs_pkg::S_DRAW_A;
            end
            lsbs_pkg::S_INV_RD: begin
                o_cmd.inv_rd = 1'b1;
                n_state      = lsbs_pkg::S_INV_WR;
            end
            lsbs_pkg::S_INV_WR: begin
                o_cmd.inv_wr = 1'b1;
                n_state = i_stat.idx_last ? lsbs_pkg::S_DONE : lsbs_pkg::S_INV_RD;
            end
            lsbs_pkg::S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = lsbs_pkg::S_IDLE;
            end
            default: begin
                n_state = lsbs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lsbs_dp.sv
// Datapath for the byte scrambler: config registers, generators, both tables,
// lookup stage and output register. Depends on lsbs_pkg; commanded by lsbs_ctrl.
module lsbs_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  logic [7:0]      i_s_axis_tdata,
    input  logic [2:0]      i_s_axis_tuser,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,
    output logic            o_m_axis_tuser,
    input  lsbs_pkg::t_cmd  i_cmd,
    output lsbs_pkg::t_stat o_stat
);

    logic [31:0] r_key_seed;
    logic [31:0] r_table_seed;
    logic [4:0]  r_mult;
    logic [31:0] r_sg;
    logic [31:0] r_gen;
    logic [7:0]  r_a;
    logic [7:0]  r_b;
    logic [7:0]  r_idx;
    logic [lsbs_pkg::SWAP_W-1:0] r_swaps;

    logic [7:0] r_fwd_mem [256];
    logic [7:0] r_inv_mem [256];
    logic [7:0] r_fwd_rd0;
    logic [7:0] r_fwd_rd1;
    logic [7:0] r_inv_rd;

    logic       r_p_valid;
    logic       r_p_is_data;
    logic       r_p_src_inv;
    logic [7:0] r_p_mask;
    logic       r_o_valid;
    logic [7:0] r_o_data;
    logic       r_o_is_data;

    logic [1:0]  opcode;
    logic        first_byte;
    logic        is_enc;
    logic        is_dec;
    logic [31:0] sg_base;
    logic [31:0] sg_next;
    logic [7:0]  ks;
    logic [31:0] gen_next;
    logic [7:0]  gen_top;
    logic        b_differs;
    logic        p_move;
    logic        fwd_we;
    logic [7:0]  fwd_wa;
    logic [7:0]  fwd_wd;
    logic        fwd_re0;
    logic [7:0]  fwd_ra0;
    logic        fwd_re1;
    logic        inv_re;
    logic [7:0]  inv_ra;

    assign opcode     = i_s_axis_tuser[1:0];
    assign first_byte = i_s_axis_tuser[2];
    assign is_enc     = i_cmd.take && (opcode == lsbs_pkg::OP_ENC);
    assign is_dec     = i_cmd.take && (opcode == lsbs_pkg::OP_DEC);
    assign sg_base    = first_byte ? r_key_seed : r_sg;
    assign sg_next    = lsbs_pkg::lcg_next(sg_base);
    assign ks         = sg_next[31:24];
    assign gen_next   = lsbs_pkg::lcg_next(r_gen);
    assign gen_top    = gen_next[31:24];
    assign b_differs  = gen_top != r_a;
    assign p_move     = r_p_valid && (!r_o_valid || i_m_axis_tready);

    assign o_stat.is_build   = opcode == lsbs_pkg::OP_BUILD;
    assign o_stat.p_valid    = r_p_valid;
    assign o_stat.p_free     = !r_p_valid || !r_o_valid || i_m_axis_tready;
    assign o_stat.idx_last   = r_idx == 8'hFF;
    assign o_stat.b_differs  = b_differs;
    assign o_stat.swaps_zero = r_swaps == '0;
    assign o_stat.swaps_last = r_swaps == lsbs_pkg::SWAP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed   <= lsbs_pkg::KEY_SEED_RESET;
            r_table_seed <= lsbs_pkg::TABLE_SEED_RESET;
            r_mult       <= lsbs_pkg::MULT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lsbs_pkg::CFG_KEY_SEED:   r_key_seed   <= i_cfg_data;
                lsbs_pkg::CFG_TABLE_SEED: r_table_seed <= i_cfg_data;
                lsbs_pkg::CFG_MULT:       r_mult       <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sg <= '0;
        end else if (is_enc || is_dec) begin
            r_sg <= sg_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_gen   <= r_table_seed;
            r_swaps <= {r_mult, 8'h00};
        end else begin
            if (i_cmd.draw_a || i_cmd.draw_b) begin
                r_gen <= gen_next;
            end
            if (i_cmd.swap_wr_b) begin
                r_swaps <= r_swaps - lsbs_pkg::SWAP_W'(1);
            end
        end
        if (i_cmd.draw_a) begin
            r_a <= gen_top;
        end
        if (i_cmd.draw_b && b_differs) begin
            r_b <= gen_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_idx <= '0;
        end else if (i_cmd.fill_wr || i_cmd.inv_wr) begin
            r_idx <= r_idx + 8'd1;
        end
    end

    always_comb begin
        fwd_we = 1'b1;
        fwd_wa = r_idx;
        fwd_wd = r_idx;
        if (i_cmd.swap_wr_a) begin
            fwd_wa = r_a;
            fwd_wd = r_fwd_rd1;
        end else if (i_cmd.swap_wr_b) begin
            fwd_wa = r_b;
            fwd_wd = r_fwd_rd0;
        end else if (!i_cmd.fill_wr) begin
            fwd_we = 1'b0;
        end
    end

    always_comb begin
        fwd_re0 = 1'b1;
        fwd_ra0 = i_s_axis_tdata;
        if (i_cmd.draw_b) begin
            fwd_re0 = b_differs;
            fwd_ra0 = r_a;
        end else if (i_cmd.inv_rd) begin
            fwd_ra0 = r_idx;
        end else if (!is_enc) begin
            fwd_re0 = 1'b0;
        end
    end

    assign fwd_re1 = i_cmd.draw_b && b_differs;
    assign inv_re  = is_dec;
    assign inv_ra  = i_s_axis_tdata ^ ks;

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[fwd_wa] <= fwd_wd;
        end
        if (fwd_re0) begin
            r_fwd_rd0 <= r_fwd_mem[fwd_ra0];
        end
        if (fwd_re1) begin
            r_fwd_rd1 <= r_fwd_mem[gen_top];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.inv_wr) begin
            r_inv_mem[r_fwd_rd0] <= r_idx;
        end
        if (inv_re) begin
            r_inv_rd <= r_inv_mem[inv_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if ((i_cmd.take && !o_stat.is_build) || i_cmd.done) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take || i_cmd.done) begin
            r_p_is_data <= is_enc || is_dec;
            r_p_src_inv <= is_dec;
            r_p_mask    <= is_enc ? ks : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_is_data <= r_p_is_data;
            if (r_p_is_data) begin
                r_o_data <= (r_p_src_inv ? r_inv_rd : r_fwd_rd0) ^ r_p_mask;
            end else begin
                r_o_data <= 8'h00;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_is_data;

endmodule

// File: bench/lsbs_checker.sv
// Scoreboard for the LCG substitution-box byte scrambler: mirrors register writes,
// predicts one result per accepted input transfer and compares output transfers in order.
// Depends on lsbs_pkg for opcodes, register indexes and reset constants.
`timescale 1ns / 100ps

module lsbs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,    // [7:0] data_in
    input  logic [2:0]  i_in_user,    // [1:0] opcode, [2] first_byte
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,   // [7:0] data_out
    input  logic        i_out_user,   // [0] is_data
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
    } t_scrambled;

    logic [7:0]  sbox_fwd [0:255];
    logic [7:0]  sbox_inv [0:255];
    logic [31:0] stream_state;
    logic [31:0] key_seed_q;
    logic [31:0] table_seed_q;
    logic [4:0]  pass_count;
    t_scrambled  scrambled_q [$];

    function automatic logic [31:0] lcg_advance(input logic [31:0] x);
        return x * lsbs_pkg::LCG_MUL + 32'd1;
    endfunction

    function automatic void shuffle_tables();
        logic [31:0] g;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  t;
        g = table_seed_q;
        for (int i = 0; i < 256; i++) sbox_fwd[i] = i[7:0];
        repeat (int'(pass_count) * 256) begin
            g = lcg_advance(g);
            a = g[31:24];
            do begin
                g = lcg_advance(g);
                b = g[31:24];
            end while (a == b);
            t           = sbox_fwd[a];
            sbox_fwd[a] = sbox_fwd[b];
            sbox_fwd[b] = t;
        end
        for (int i = 0; i < 256; i++) sbox_inv[sbox_fwd[i]] = i[7:0];
    endfunction

    function automatic t_scrambled scramble(input logic [1:0] op, input logic [7:0] din,
                                            input logic first);
        t_scrambled r;
        logic [7:0] ks;
        r = '0;
        case (op)
            lsbs_pkg::OP_BUILD: shuffle_tables();
            lsbs_pkg::OP_ENC, lsbs_pkg::OP_DEC: begin
                if (first) stream_state = key_seed_q;
                stream_state = lcg_advance(stream_state);
                ks = stream_state[31:24];
                r.is_data  = 1'b1;
                r.out_byte = (op == lsbs_pkg::OP_ENC) ? (sbox_fwd[din] ^ ks)
                                                      : sbox_inv[din ^ ks];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_scrambled seen;
        t_scrambled want;
        if (!i_rst_n) begin
            stream_state = '0;
            key_seed_q   = lsbs_pkg::KEY_SEED_RESET;
            table_seed_q = lsbs_pkg::TABLE_SEED_RESET;
            pass_count   = lsbs_pkg::MULT_RESET;
            o_fail_count = 0;
            scrambled_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lsbs_pkg::CFG_KEY_SEED:   key_seed_q   = i_cfg_data;
                    lsbs_pkg::CFG_TABLE_SEED: table_seed_q = i_cfg_data;
                    lsbs_pkg::CFG_MULT:       pass_count   = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                seen = {i_out_data, i_out_user};
                if (scrambled_q.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %02h/%0b",
                             $time, seen.out_byte, seen.is_data);
                    o_fail_count++;
                end else begin
                    want = scrambled_q.pop_front();
                    if (seen.out_byte !== want.out_byte) begin
                        $display("%0t: data_out expected %02h actual %02h",
                                 $time, want.out_byte, seen.out_byte);
                        o_fail_count++;
                    end
                    if (seen.is_data !== want.is_data) begin
                        $display("%0t: is_data expected %0b actual %0b",
                                 $time, want.is_data, seen.is_data);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                scrambled_q.push_back(scramble(i_in_user[1:0], i_in_data, i_in_user[2]));
        end
        o_pending = scrambled_q.size();
    end

endmodule

// File: bench/lcg_sbox_byte_scrambler_test.sv
// Top of the scrambler bench: clock, reset, register writes, input stimulus with random
// gaps, output back-pressure, watchdog and verdict.
// Depends on lsbs_pkg, lcg_sbox_byte_scrambler and lsbs_checker.
`timescale 1ns / 100ps

module lcg_sbox_byte_scrambler_test;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 150000;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 272;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data    = '0;
    logic [2:0]  s_user    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_data;
    logic        m_user;
    int          fail_count;
    int          pending;
    int          delivered = 0;
    int          idle_cycles = 0;
    int          hold_left = 0;
    bit          calm = 1'b0;
    bit          pressed = 1'b0;

    lcg_sbox_byte_scrambler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    lsbs_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_in_user    (s_user),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_out_user   (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (m_valid && m_ready) delivered <= delivered + 1;
        if ((m_valid && m_ready) || (s_valid && s_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall bursts, one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm) begin
                if (!pressed && delivered >= 300) begin
                    pressed   <= 1'b1;
                    hold_left <= 600;
                end else if ($urandom_range(0, 15) == 0) begin
                    hold_left <= $urandom_range(1, 19);
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] din, input logic first);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= din;
        s_user  <= {first, op};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input int items, input bit heavy);
        int         sent;
        int         len;
        int         roll;
        logic [1:0] op;
        logic       first;
        write_cfg(lsbs_pkg::CFG_KEY_SEED, $urandom());
        write_cfg(lsbs_pkg::CFG_TABLE_SEED, $urandom());
        write_cfg(lsbs_pkg::CFG_MULT, heavy ? 32'd16 : $urandom_range(1, 4));
        send_item(lsbs_pkg::OP_BUILD, $urandom_range(0, 255), $urandom_range(0, 1));
        sent = 1;
        while (sent < items) begin
            len = $urandom_range(1, 40);
            for (int k = 0; k < len && sent < items; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    op = OP_UNUSED;
                else if (roll < 3)
                    op = lsbs_pkg::OP_BUILD;
                else
                    op = $urandom_range(0, 1) ? lsbs_pkg::OP_ENC : lsbs_pkg::OP_DEC;
                roll  = $urandom_range(0, 99);
                first = (k == 0) ? (roll < 95) : (roll >= 97);
                send_item(op, $urandom_range(0, 255), first);
                sent++;
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values; build ignores its first flag
        send_item(lsbs_pkg::OP_BUILD, 8'h00, 1'b1);
        send_item(lsbs_pkg::OP_ENC, 8'h00, 1'b1);
        send_item(lsbs_pkg::OP_ENC, 8'hff, 1'b0);
        send_item(lsbs_pkg::OP_DEC, 8'h00, 1'b1);
        send_item(lsbs_pkg::OP_DEC, 8'hff, 1'b0);
        send_item(OP_UNUSED, 8'hff, 1'b1);
        send_item(lsbs_pkg::OP_ENC, 8'h5a, 1'b0);
        wait_idle();

        // zero passes leaves the identity table
        write_cfg(lsbs_pkg::CFG_KEY_SEED, 32'h0000_0000);
        write_cfg(lsbs_pkg::CFG_TABLE_SEED, 32'h0000_0000);
        write_cfg(lsbs_pkg::CFG_MULT, 32'd0);
        send_item(lsbs_pkg::OP_BUILD, 8'hff, 1'b0);
        send_item(lsbs_pkg::OP_ENC, 8'h00, 1'b1);
        send_item(lsbs_pkg::OP_DEC, 8'hff, 1'b0);
        send_item(lsbs_pkg::OP_ENC, 8'h80, 1'b0);
        wait_idle();

        // largest pass count the register holds
        write_cfg(lsbs_pkg::CFG_KEY_SEED, 32'hffff_ffff);
        write_cfg(lsbs_pkg::CFG_TABLE_SEED, 32'hffff_ffff);
        write_cfg(lsbs_pkg::CFG_MULT, 32'd31);
        send_item(lsbs_pkg::OP_BUILD, 8'h00, 1'b0);
        send_item(lsbs_pkg::OP_ENC, 8'hff, 1'b1);
        send_item(lsbs_pkg::OP_DEC, 8'h00, 1'b1);
        wait_idle();

        write_cfg(lsbs_pkg::CFG_TABLE_SEED, $urandom());
        write_cfg(lsbs_pkg::CFG_MULT, 32'd1);
        send_item(lsbs_pkg::OP_BUILD, 8'h00, 1'b0);
        send_item(lsbs_pkg::OP_ENC, $urandom_range(0, 255), 1'b1);
        send_item(lsbs_pkg::OP_DEC, $urandom_range(0, 255), 1'b0);
        wait_idle();

        write_cfg(lsbs_pkg::CFG_KEY_SEED, $urandom());
        write_cfg(lsbs_pkg::CFG_MULT, 32'd16);
        send_item(lsbs_pkg::OP_BUILD, 8'h00, 1'b0);
        send_item(lsbs_pkg::OP_ENC, $urandom_range(0, 255), 1'b1);
        send_item(lsbs_pkg::OP_DEC, $urandom_range(0, 255), 1'b0);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1) calm = 1'b1;
            run_phase(PHASE_ITEMS, p == 2);
        end

        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
